// ===== rtl/i4gdq_pkg.sv =====
// ----------------------------------------------------------------------------
// i4gdq_pkg
// Shared types, constants and helpers for the int4 group dequant dot product.
// ----------------------------------------------------------------------------
package i4gdq_pkg;

   localparam int MantW    = 50;
   localparam int ExpW     = 12;
   localparam int ActW     = 32;
   localparam int CodeW    = 4;
   localparam int ScaleW   = 16;
   localparam int SumW     = 32;

   localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
   localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;
   localparam logic [7:0]  EXP_MAX      = 8'hFF;

   typedef struct packed {
      logic load;
      logic mul_go;
      logic mul_second;
      logic add_align;
      logic add_sum;
      logic norm_go;
      logic rnd_mul;
      logic rnd_add;
   } cmd_type;

   typedef struct packed {
      logic last;
   } status_type;

   // weight = code - 8, as fp32
   function automatic logic [31:0] weight_to_fp32(input logic [CodeW-1:0] code);
      logic [31:0] r;
      case (code)
         4'd0:    r = 32'hC100_0000;
         4'd1:    r = 32'hC0E0_0000;
         4'd2:    r = 32'hC0C0_0000;
         4'd3:    r = 32'hC0A0_0000;
         4'd4:    r = 32'hC080_0000;
         4'd5:    r = 32'hC040_0000;
         4'd6:    r = 32'hC000_0000;
         4'd7:    r = 32'hBF80_0000;
         4'd8:    r = 32'h0000_0000;
         4'd9:    r = 32'h3F80_0000;
         4'd10:   r = 32'h4000_0000;
         4'd11:   r = 32'h4040_0000;
         4'd12:   r = 32'h4080_0000;
         4'd13:   r = 32'h40A0_0000;
         4'd14:   r = 32'h40C0_0000;
         default: r = 32'h40E0_0000;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/i4gdq_round.sv =====
// ----------------------------------------------------------------------------
// i4gdq_round
// Shared normalize and round-to-nearest-even unit; leading-zero count and
// shift amount are registered, shift/round/pack follow in the next cycle.
// ----------------------------------------------------------------------------
module i4gdq_round (
   input  logic                                clock,
   input  logic                                load,
   input  logic                                in_sign,
   input  logic signed [i4gdq_pkg::ExpW-1:0]   in_exp,
   input  logic [i4gdq_pkg::MantW-1:0]         in_mant,
   input  logic                                in_spec_v,
   input  logic [31:0]                         in_spec,
   output logic [31:0]                         result
);

   localparam int W  = i4gdq_pkg::MantW;
   localparam int EW = i4gdq_pkg::ExpW;

   logic [5:0]           lz;
   logic signed [EW-1:0] e_lz;
   logic                 left_in;
   logic [5:0]           amt_in;
   logic signed [EW-1:0] eo_in;
   logic signed [EW-1:0] rshift;

   logic                 sign_ff;
   logic signed [EW-1:0] eo_ff;
   logic [W-1:0]         mant_ff;
   logic                 left_ff;
   logic [5:0]           amt_ff;
   logic                 spec_v_ff;
   logic [31:0]          spec_ff;

   always_comb begin
      lz = 6'(W);
      for (int i = 0; i < W; i++) begin
         if (in_mant[i]) begin
            lz = 6'(W - 1 - i);
         end
      end
      e_lz   = in_exp - EW'(lz);
      rshift = EW'(1) - in_exp;
      if (e_lz >= EW'(1)) begin
         left_in = 1'b1;
         amt_in  = lz;
         eo_in   = e_lz;
      end else if (in_exp >= EW'(1)) begin
         left_in = 1'b1;
         amt_in  = 6'(in_exp - EW'(1));
         eo_in   = EW'(1);
      end else begin
         left_in = 1'b0;
         amt_in  = (rshift > EW'(W)) ? 6'(W) : 6'(rshift);
         eo_in   = EW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sign_ff   <= in_sign;
         eo_ff     <= eo_in;
         mant_ff   <= in_mant;
         left_ff   <= left_in;
         amt_ff    <= amt_in;
         spec_v_ff <= in_spec_v;
         spec_ff   <= in_spec;
      end
   end

   logic [W-1:0]         mm;
   logic                 st2;
   logic [23:0]          m24;
   logic                 guard;
   logic                 stk;
   logic [24:0]          s25;
   logic signed [EW-1:0] ex;
   logic [22:0]          frac;

   always_comb begin
      mm    = left_ff ? (mant_ff << amt_ff) : (mant_ff >> amt_ff);
      st2   = !left_ff && |(mant_ff & ~({W{1'b1}} << amt_ff));
      m24   = mm[W-1:W-24];
      guard = mm[W-25];
      stk   = |mm[W-26:0] | st2;
      s25   = {1'b0, m24} + 25'(guard & (stk | m24[0]));
      if (s25[24]) begin
         frac = 23'd0;
         ex   = eo_ff + EW'(1);
      end else begin
         frac = s25[22:0];
         ex   = s25[23] ? eo_ff : EW'(0);
      end
      if (spec_v_ff) begin
         result = spec_ff;
      end else if (ex >= EW'(255)) begin
         result = {sign_ff, i4gdq_pkg::EXP_MAX, 23'd0};
      end else begin
         result = {sign_ff, ex[7:0], frac};
      end
   end

endmodule

// ===== rtl/i4gdq_datapath.sv =====
// ----------------------------------------------------------------------------
// i4gdq_datapath
// Operand registers, fp32 multiplier front end, adder alignment and the
// running sum; rounding goes through the shared round unit.
// ----------------------------------------------------------------------------
module i4gdq_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  i4gdq_pkg::cmd_type                  cmd,
   output i4gdq_pkg::status_type               status,
   input  logic [i4gdq_pkg::ActW-1:0]          in_act,
   input  logic [i4gdq_pkg::CodeW-1:0]         in_code,
   input  logic [i4gdq_pkg::ScaleW-1:0]        in_scale,
   input  logic                                in_last,
   output logic [i4gdq_pkg::SumW-1:0]          out_sum
);

   localparam int W  = i4gdq_pkg::MantW;
   localparam int EW = i4gdq_pkg::ExpW;

   logic [31:0] act_ff, wbits_ff, scale_ff, res_ff, sum_ff, out_ff;
   logic        last_ff;

   // front register feeding the round unit
   logic                 fr_s_ff, fr_s_in;
   logic signed [EW-1:0] fr_e_ff, fr_e_in;
   logic [W-1:0]         fr_m_ff, fr_m_in;
   logic                 fr_sv_ff, fr_sv_in;
   logic [31:0]          fr_sp_ff, fr_sp_in;

   // adder alignment register
   logic        ad_s_ff, ad_sub_ff, ad_sv_ff;
   logic [7:0]  ad_e_ff, ad_d_ff;
   logic [23:0] ad_mb_ff, ad_ms_ff;
   logic [31:0] ad_sp_ff;

   logic        ad_s_in, ad_sub_in, ad_sv_in;
   logic [7:0]  ad_e_in, ad_d_in;
   logic [23:0] ad_mb_in, ad_ms_in;
   logic [31:0] ad_sp_in;

   logic [31:0] rnd_result;

   // multiplier
   logic [31:0] ma_op, mb_op;
   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, m_sign;
   logic [7:0]  ea, eb;
   logic [23:0] sa, sb;
   logic [47:0] prod;
   logic        m_sv;
   logic [31:0] m_sp;

   always_comb begin
      ma_op  = cmd.mul_second ? res_ff : act_ff;
      mb_op  = cmd.mul_second ? scale_ff : wbits_ff;
      a_nan  = (ma_op[30:23] == i4gdq_pkg::EXP_MAX) && (ma_op[22:0] != 23'd0);
      b_nan  = (mb_op[30:23] == i4gdq_pkg::EXP_MAX) && (mb_op[22:0] != 23'd0);
      a_inf  = (ma_op[30:23] == i4gdq_pkg::EXP_MAX) && (ma_op[22:0] == 23'd0);
      b_inf  = (mb_op[30:23] == i4gdq_pkg::EXP_MAX) && (mb_op[22:0] == 23'd0);
      a_zero = (ma_op[30:0] == 31'd0);
      b_zero = (mb_op[30:0] == 31'd0);
      m_sign = ma_op[31] ^ mb_op[31];
      ea     = (ma_op[30:23] == 8'd0) ? 8'd1 : ma_op[30:23];
      eb     = (mb_op[30:23] == 8'd0) ? 8'd1 : mb_op[30:23];
      sa     = {ma_op[30:23] != 8'd0, ma_op[22:0]};
      sb     = {mb_op[30:23] != 8'd0, mb_op[22:0]};
      prod   = 48'(sa) * 48'(sb);
      m_sv   = 1'b1;
      if (a_nan) begin
         m_sp = ma_op | i4gdq_pkg::QUIET_BIT;
      end else if (b_nan) begin
         m_sp = mb_op | i4gdq_pkg::QUIET_BIT;
      end else if ((a_inf && b_zero) || (b_inf && a_zero)) begin
         m_sp = i4gdq_pkg::QNAN_DEFAULT;
      end else if (a_inf || b_inf) begin
         m_sp = {m_sign, i4gdq_pkg::EXP_MAX, 23'd0};
      end else begin
         m_sv = 1'b0;
         m_sp = 32'd0;
      end
   end

   // adder alignment
   logic [31:0] x_op, y_op, big, lesser;
   logic        x_nan, y_nan, x_inf, y_inf;

   always_comb begin
      x_op  = sum_ff;
      y_op  = res_ff;
      x_nan = (x_op[30:23] == i4gdq_pkg::EXP_MAX) && (x_op[22:0] != 23'd0);
      y_nan = (y_op[30:23] == i4gdq_pkg::EXP_MAX) && (y_op[22:0] != 23'd0);
      x_inf = (x_op[30:23] == i4gdq_pkg::EXP_MAX) && (x_op[22:0] == 23'd0);
      y_inf = (y_op[30:23] == i4gdq_pkg::EXP_MAX) && (y_op[22:0] == 23'd0);
      if (x_op[30:0] >= y_op[30:0]) begin
         big    = x_op;
         lesser = y_op;
      end else begin
         big    = y_op;
         lesser = x_op;
      end
      ad_s_in   = big[31];
      ad_sub_in = x_op[31] ^ y_op[31];
      ad_e_in   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      ad_mb_in  = {big[30:23] != 8'd0, big[22:0]};
      ad_ms_in  = {lesser[30:23] != 8'd0, lesser[22:0]};
      ad_d_in   = ad_e_in - ((lesser[30:23] == 8'd0) ? 8'd1 : lesser[30:23]);
      ad_sv_in  = 1'b1;
      if (x_nan) begin
         ad_sp_in = x_op | i4gdq_pkg::QUIET_BIT;
      end else if (y_nan) begin
         ad_sp_in = y_op | i4gdq_pkg::QUIET_BIT;
      end else if (x_inf && y_inf && (x_op[31] != y_op[31])) begin
         ad_sp_in = i4gdq_pkg::QNAN_DEFAULT;
      end else if (x_inf) begin
         ad_sp_in = x_op;
      end else if (y_inf) begin
         ad_sp_in = y_op;
      end else begin
         ad_sv_in = 1'b0;
         ad_sp_in = 32'd0;
      end
   end

   // adder sum
   logic [W-1:0] big_full, small_full, small_sh;
   logic         lost;
   logic [W-1:0] add_m;

   always_comb begin
      big_full   = {1'b0, ad_mb_ff, 25'd0};
      small_full = {1'b0, ad_ms_ff, 25'd0};
      if (ad_d_ff >= 8'(W)) begin
         small_sh = '0;
         lost     = |ad_ms_ff;
      end else begin
         small_sh = small_full >> ad_d_ff;
         lost     = |(small_full & ~({W{1'b1}} << ad_d_ff));
      end
      add_m = ad_sub_ff ? (big_full - (small_sh | W'(lost)))
                        : (big_full + (small_sh | W'(lost)));
   end

   always_comb begin
      if (cmd.add_sum) begin
         fr_s_in  = (add_m == '0) ? (ad_sub_ff ? 1'b0 : ad_s_ff) : ad_s_ff;
         fr_e_in  = EW'({4'd0, ad_e_ff}) + EW'(1);
         fr_m_in  = add_m;
         fr_sv_in = ad_sv_ff;
         fr_sp_in = ad_sp_ff;
      end else begin
         fr_s_in  = m_sign;
         fr_e_in  = EW'({4'd0, ea}) + EW'({4'd0, eb}) - EW'(126);
         fr_m_in  = {prod, 2'b00};
         fr_sv_in = m_sv;
         fr_sp_in = m_sp;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff   <= in_act;
         wbits_ff <= i4gdq_pkg::weight_to_fp32(in_code);
         scale_ff <= {in_scale, 16'd0};
         last_ff  <= in_last;
      end
      if (cmd.mul_go || cmd.add_sum) begin
         fr_s_ff  <= fr_s_in;
         fr_e_ff  <= fr_e_in;
         fr_m_ff  <= fr_m_in;
         fr_sv_ff <= fr_sv_in;
         fr_sp_ff <= fr_sp_in;
      end
      if (cmd.add_align) begin
         ad_s_ff   <= ad_s_in;
         ad_sub_ff <= ad_sub_in;
         ad_e_ff   <= ad_e_in;
         ad_d_ff   <= ad_d_in;
         ad_mb_ff  <= ad_mb_in;
         ad_ms_ff  <= ad_ms_in;
         ad_sv_ff  <= ad_sv_in;
         ad_sp_ff  <= ad_sp_in;
      end
      if (cmd.rnd_mul) begin
         res_ff <= rnd_result;
      end
      if (cmd.rnd_add && last_ff) begin
         out_ff <= rnd_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= 32'd0;
      end else if (cmd.rnd_add) begin
         sum_ff <= last_ff ? 32'd0 : rnd_result;
      end
   end

   i4gdq_round u_round (
      .clock     (clock),
      .load      (cmd.norm_go),
      .in_sign   (fr_s_ff),
      .in_exp    (fr_e_ff),
      .in_mant   (fr_m_ff),
      .in_spec_v (fr_sv_ff),
      .in_spec   (fr_sp_ff),
      .result    (rnd_result)
   );

   assign status.last = last_ff;
   assign out_sum     = out_ff;

endmodule

// ===== rtl/i4gdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// i4gdq_ctrl
// Sequencer: two multiplies and one add through the shared round unit,
// then the result handshake.
// ----------------------------------------------------------------------------
module i4gdq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  i4gdq_pkg::status_type  status,
   output i4gdq_pkg::cmd_type     cmd
);

   typedef enum logic [10:0] {
      ST_IDLE = 11'b000_0000_0001,
      ST_M1   = 11'b000_0000_0010,
      ST_N1   = 11'b000_0000_0100,
      ST_R1   = 11'b000_0000_1000,
      ST_M2   = 11'b000_0001_0000,
      ST_N2   = 11'b000_0010_0000,
      ST_R2   = 11'b000_0100_0000,
      ST_A1   = 11'b000_1000_0000,
      ST_A2   = 11'b001_0000_0000,
      ST_N3   = 11'b010_0000_0000,
      ST_R3   = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_M1;
            end
         end
         ST_M1: begin
            cmd.mul_go = 1'b1;
            state_in   = ST_N1;
         end
         ST_N1: begin
            cmd.norm_go = 1'b1;
            state_in    = ST_R1;
         end
         ST_R1: begin
            cmd.rnd_mul = 1'b1;
            state_in    = ST_M2;
         end
         ST_M2: begin
            cmd.mul_go     = 1'b1;
            cmd.mul_second = 1'b1;
            state_in       = ST_N2;
         end
         ST_N2: begin
            cmd.norm_go = 1'b1;
            state_in    = ST_R2;
         end
         ST_R2: begin
            cmd.rnd_mul = 1'b1;
            state_in    = ST_A1;
         end
         ST_A1: begin
            cmd.add_align = 1'b1;
            state_in      = ST_A2;
         end
         ST_A2: begin
            cmd.add_sum = 1'b1;
            state_in    = ST_N3;
         end
         ST_N3: begin
            cmd.norm_go = 1'b1;
            state_in    = ST_R3;
         end
         ST_R3: begin
            if (!status.last || out_free) begin
               cmd.rnd_add = 1'b1;
               state_in    = ST_IDLE;
               if (status.last) begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_load_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_M1))
      else $error("accepted request did not start the sequence");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_R3))
      else $error("response raised outside the final round step");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.rnd_add && status.last) |-> out_free)
      else $error("pending response overwritten");

   a_mid_row_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_R3 && !status.last) |=> (state_ff == ST_IDLE))
      else $error("mid-row column did not finish");

endmodule

// ===== rtl/int4_group_dequant_dot_product_top.sv =====
// ----------------------------------------------------------------------------
// int4_group_dequant_dot_product_top
// Int4 groupwise dequantizing fp32 dot product with bf16 group scales.
// ----------------------------------------------------------------------------
// Each request is accepted in the idle state, then runs the two fp32
// multiplies and the accumulate add, each passing through one shared
// normalize/round unit (multiply or align, leading-zero count, round), plus
// one add step; the next request is accepted only back in idle. The
// running sum is carried from one request to the next. A request with
// last_column set loads the row sum into the response register and clears the
// sum; the block keeps accepting requests while that response waits, and
// stalls only if another row finishes before it is taken.
module int4_group_dequant_dot_product_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [i4gdq_pkg::ActW-1:0]          req_activation_bits,
   input  logic [i4gdq_pkg::CodeW-1:0]         req_weight_code,
   input  logic [i4gdq_pkg::ScaleW-1:0]        req_group_scale,
   input  logic                                req_last_column,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [i4gdq_pkg::SumW-1:0]          rsp_row_sum_bits
);

   i4gdq_pkg::cmd_type    cmd;
   i4gdq_pkg::status_type status;

   i4gdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   i4gdq_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .in_act   (req_activation_bits),
      .in_code  (req_weight_code),
      .in_scale (req_group_scale),
      .in_last  (req_last_column),
      .out_sum  (rsp_row_sum_bits)
   );

endmodule
